// ===== rtl/svt_pkg.sv =====
`default_nettype none

package svt_pkg;

	// table geometry
	localparam int DEPTH       = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int POS_W       = 4;
	localparam int CNT_W       = 5;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	// status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// command broadcast to every cell
	typedef struct packed {
		logic                          ins;
		logic                          rem;
		logic signed [VALUE_WIDTH-1:0] value;
	} svt_cmd_t;

	// result of one transaction
	typedef struct packed {
		logic [1:0]       status;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] occupancy;
	} svt_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_value_table.sv =====
// Sorted table of signed values kept in a row of compare-and-shift cells.
// Results are registered in the output stage, or in the skid stage while one waits.
// One transaction per cycle unless stalled; every cell compares and shifts in parallel.
// A two-deep output stage lets a new transaction in while one result waits.
// Reset clears the entry count and the output stage; entries are not cleared,
// and slots past the count are masked out of every compare.
`default_nettype none

module sorted_value_table
	import svt_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output      logic                          req_stall,
	input  wire logic [1:0]                    operation,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	output      logic                          rsp_valid,
	input  wire logic                          rsp_stall,
	output      logic [1:0]                    status,
	output      logic [POS_W-1:0]              position,
	output      logic [CNT_W-1:0]              occupancy
);

	logic [CNT_W-1:0]              count_q;
	logic                          rsp_valid_q;
	logic                          skid_valid_q;
	svt_rsp_t                      rsp_q;
	svt_rsp_t                      skid_q;
	svt_rsp_t                      rsp_new;
	svt_cmd_t                      cmd;
	logic                          accept;
	logic                          pop;
	logic                          full;
	logic                          found;
	logic [POS_W-1:0]              at;
	logic [CNT_W-1:0]              count_new;
	logic [DEPTH-1:0]              cell_valid;
	logic [DEPTH-1:0]              lt_w;
	logic [DEPTH-1:0]              eq_w;
	logic [DEPTH-1:0]              bound_w;
	logic [DEPTH-1:0]              left_lt_w;
	logic signed [VALUE_WIDTH-1:0] entry_w [DEPTH];
	logic signed [VALUE_WIDTH-1:0] left_w  [DEPTH];
	logic signed [VALUE_WIDTH-1:0] right_w [DEPTH];

	// handshake
	assign req_stall = skid_valid_q;
	assign accept    = req_valid && !skid_valid_q;
	assign pop       = rsp_valid_q && !rsp_stall;
	assign full      = (count_q == CNT_W'(DEPTH));

	// broadcast command
	always_comb begin
		cmd.value = value;
		cmd.ins   = accept && (operation == OP_INSERT) && !full;
		cmd.rem   = accept && (operation == OP_REMOVE) && found;
	end

	// row of cells
	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		assign cell_valid[gi] = (count_q > CNT_W'(gi));
		if (gi == 0) begin : g_first
			assign left_lt_w[gi] = 1'b1;
			assign left_w[gi]    = entry_w[gi];
		end else begin : g_mid
			assign left_lt_w[gi] = lt_w[gi-1];
			assign left_w[gi]    = entry_w[gi-1];
		end
		if (gi == DEPTH - 1) begin : g_last
			assign right_w[gi] = entry_w[gi];
		end else begin : g_inner
			assign right_w[gi] = entry_w[gi+1];
		end
		svt_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.valid       (cell_valid[gi]),
			.left_lt     (left_lt_w[gi]),
			.left_entry  (left_w[gi]),
			.right_entry (right_w[gi]),
			.entry       (entry_w[gi]),
			.lt          (lt_w[gi]),
			.eq          (eq_w[gi]),
			.bound       (bound_w[gi])
		);
	end

	// encode the boundary slot and detect a match there
	always_comb begin
		at = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (bound_w[i]) begin
				at = at | POS_W'(i);
			end
		end
		found = |(bound_w & eq_w);
	end

	// build the result and the next count
	always_comb begin
		rsp_new.status   = ST_MISSING;
		rsp_new.position = '0;
		count_new        = count_q;
		case (operation)
			OP_INSERT: begin
				if (full) begin
					rsp_new.status = ST_FULL;
				end else begin
					rsp_new.status   = ST_DONE;
					rsp_new.position = at;
					count_new        = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (found) begin
					rsp_new.status   = ST_DONE;
					rsp_new.position = at;
					count_new        = count_q - CNT_W'(1);
				end
			end
			OP_SEARCH: begin
				if (found) begin
					rsp_new.status   = ST_DONE;
					rsp_new.position = at;
				end
			end
			default: begin
				rsp_new.status = ST_MISSING;
			end
		endcase
		rsp_new.occupancy = count_new;
	end

	// hold the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_new;
		end
	end

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (!rsp_valid_q || pop) begin
				rsp_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				rsp_q <= skid_q;
			end
		end else if (accept) begin
			if (!rsp_valid_q || pop) begin
				rsp_q <= rsp_new;
			end else begin
				skid_q <= rsp_new;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = rsp_q.status;
	assign position  = rsp_q.position;
	assign occupancy = rsp_q.occupancy;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds table depth");

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> rsp_valid_q)
		else $error("skid stage holds a result while output is empty");

	a_bound_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(bound_w))
		else $error("more than one insertion boundary");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the count");

	a_remove_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rem |-> (count_q != '0))
		else $error("remove hit on an empty table");
`endif

endmodule

`default_nettype wire

// ===== rtl/svt_cell.sv =====
`default_nettype none

module svt_cell
	import svt_pkg::*;
(
	input  wire logic                          clk,
	input  wire svt_cmd_t                      cmd,
	input  wire logic                          valid,
	input  wire logic                          left_lt,
	input  wire logic signed [VALUE_WIDTH-1:0] left_entry,
	input  wire logic signed [VALUE_WIDTH-1:0] right_entry,
	output      logic signed [VALUE_WIDTH-1:0] entry,
	output      logic                          lt,
	output      logic                          eq,
	output      logic                          bound
);

	logic signed [VALUE_WIDTH-1:0] entry_q;

	// compare the held entry with the broadcast value
	assign lt    = valid && (entry_q < cmd.value);
	assign eq    = valid && (entry_q == cmd.value);
	assign bound = !lt && left_lt;
	assign entry = entry_q;

	// cells at or above the boundary open a slot or close the gap
	always_ff @(posedge clk) begin
		if (cmd.ins && !lt) begin
			entry_q <= left_lt ? cmd.value : left_entry;
		end else if (cmd.rem && !lt) begin
			entry_q <= right_entry;
		end
	end

endmodule

`default_nettype wire
